// ===== hw/rtl/acmrr_pkg.sv =====
// Package for the associative cache with MRU / random replacement.
// Holds field widths, defaults, codes, the state type and the LFSR step.
// No dependencies.
package acmrr_pkg;

  localparam int ENTRIES_DEF      = 16;
  localparam int PAYLOAD_BITS_DEF = 64;

  localparam int KEY_W       = 32;
  localparam int PAYLOAD_W   = 64;
  localparam int SLOT_W      = 4;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_TUSER_W = 2;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam int LFSR_W = 16;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

  // Register indexes of the configuration port.
  localparam logic [0:0] REG_REPLACE_POLICY = 1'b0;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } op_t;

  typedef enum logic {
    POLICY_MRU    = 1'b0,
    POLICY_RANDOM = 1'b1
  } policy_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_RESP
  } state_t;

  // One Galois step: shift right, fold in the taps when a one drops out.
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
    logic [LFSR_W-1:0] shifted;
    shifted = s >> 1;
    return s[0] ? (shifted ^ LFSR_TAPS) : shifted;
  endfunction

endpackage

// ===== hw/rtl/acmrr_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Read data holds while no read is enabled. No dependencies.
module acmrr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/assoc_cache_mru_random_replace.sv =====
// Top level of the fully associative cache with MRU or random replacement.
// Depends on acmrr_pkg and instantiates acmrr_ram for the payload store.
//
// A fully associative cache of ENTRIES keyed payload words. Keys and valid
// bits sit in per-slot registers that are all compared in parallel against
// the request key; payloads live in a synchronous RAM. An item passes a
// compare state, in which inserts are written and lookups start the payload
// read, and a response state that loads the output register when it is free
// and may take the next item at once. The pseudo-random victim is reduced
// modulo ENTRIES in a two-stage multiply pipeline after each LFSR step, so an
// insert that evicts a random slot waits in the compare state until the
// pipeline has settled. Lookups of the same key return the lowest matching
// slot; no duplicate check is made on insert.
// replace_policy sits at byte address 0 and must only be written while the
// block is idle.
module assoc_cache_mru_random_replace #(
  parameter int ENTRIES      = acmrr_pkg::ENTRIES_DEF,
  parameter int PAYLOAD_BITS = acmrr_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input items.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // tdata: key [31:0], payload_in [95:32]
  input  logic [acmrr_pkg::IN_TDATA_W-1:0]    in_tdata,
  // tuser: operation [0]
  input  logic                                in_tuser,
  // Result items.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // tdata: payload_out [63:0], slot [67:64], zero [71:68]
  output logic [acmrr_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // tuser: hit [0], evicted [1]
  output logic [acmrr_pkg::OUT_TUSER_W-1:0]   out_tuser,
  // Configuration port.
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [acmrr_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [acmrr_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [acmrr_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                cfg_pready
);

  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int LFSR_W  = acmrr_pkg::LFSR_W;
  localparam int KEY_W   = acmrr_pkg::KEY_W;
  localparam int SLOT_W  = acmrr_pkg::SLOT_W;
  localparam int PW      = acmrr_pkg::PAYLOAD_W;
  // Reciprocal for the modulo of a 16-bit value; exact for ENTRIES <= 256.
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / ENTRIES + 1);
  localparam logic [31:0] ENT32 = 32'(ENTRIES);

  // ---------------------------------------------------------------------
  // Configuration register.
  logic cfg_wr;
  acmrr_pkg::policy_t policy_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                  (cfg_paddr[acmrr_pkg::CFG_ADDR_W-1:2] ==
                   acmrr_pkg::REG_REPLACE_POLICY);
  assign cfg_prdata = (cfg_paddr[acmrr_pkg::CFG_ADDR_W-1:2] ==
                       acmrr_pkg::REG_REPLACE_POLICY) ?
                      {{(acmrr_pkg::CFG_DATA_W-1){1'b0}}, policy_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= acmrr_pkg::POLICY_MRU;
    end else if (cfg_wr) begin
      policy_r <= acmrr_pkg::policy_t'(cfg_pwdata[0]);
    end
  end

  // ---------------------------------------------------------------------
  // Control.
  acmrr_pkg::state_t state_r, state_nxt;
  logic in_accept;
  logic out_free;
  logic load_out;
  logic do_match;
  logic rnd_wait;

  acmrr_pkg::op_t    req_op_r;
  logic [KEY_W-1:0]  req_key_r;
  logic [PAYLOAD_BITS-1:0] req_pay_r;

  logic             valid_r [ENTRIES];
  logic [KEY_W-1:0] key_r   [ENTRIES];
  logic [IDX_W-1:0] recent_r;
  logic [LFSR_W-1:0] lfsr_r;
  logic [1:0]        rnd_cnt_r;
  logic [LFSR_W-1:0] rnd_next;
  logic [LFSR_W-1:0] rnd_val_r;
  logic [LFSR_W-1:0] rnd_q_r;
  logic [47:0]       rnd_prod;
  logic [31:0]       rnd_qe;
  logic [LFSR_W-1:0] rnd_rem;
  logic [IDX_W-1:0]  rnd_slot_r;

  logic             hit_any;
  logic [IDX_W-1:0] hit_idx;
  logic             free_any;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] target;
  logic             is_insert;

  logic             res_hit_r;
  logic             res_evict_r;
  logic [IDX_W-1:0] res_slot_r;
  logic [PAYLOAD_BITS-1:0] ram_rdata;

  logic                                out_tvalid_r;
  logic [acmrr_pkg::OUT_TDATA_W-1:0]   out_tdata_r;
  logic [acmrr_pkg::OUT_TUSER_W-1:0]   out_tuser_r;
  logic [IDX_W+SLOT_W-1:0]             slot_wide;
  logic [PW-1:0]                       pay_out;

  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign is_insert = (req_op_r == acmrr_pkg::OP_INSERT);
  assign rnd_wait  = is_insert && !free_any && (policy_r == acmrr_pkg::POLICY_RANDOM) &&
                     (rnd_cnt_r != 2'd0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      acmrr_pkg::ST_IDLE: begin
        if (in_accept) state_nxt = acmrr_pkg::ST_MATCH;
      end
      acmrr_pkg::ST_MATCH: begin
        if (!rnd_wait) state_nxt = acmrr_pkg::ST_RESP;
      end
      acmrr_pkg::ST_RESP: begin
        if (out_free) begin
          state_nxt = in_accept ? acmrr_pkg::ST_MATCH : acmrr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = acmrr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    load_out  = 1'b0;
    do_match  = 1'b0;
    unique case (state_r)
      acmrr_pkg::ST_IDLE:  in_tready = 1'b1;
      acmrr_pkg::ST_MATCH: do_match  = !rnd_wait;
      acmrr_pkg::ST_RESP: begin
        in_tready = out_free;
        load_out  = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= acmrr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Request register.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_op_r  <= acmrr_pkg::op_t'(in_tuser);
      req_key_r <= in_tdata[KEY_W-1:0];
      req_pay_r <= in_tdata[KEY_W +: PAYLOAD_BITS];
    end
  end

  // ---------------------------------------------------------------------
  // Parallel tag compare and free-slot search; the lowest slot wins.
  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && (key_r[i] == req_key_r)) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    if (free_any) begin
      target = free_idx;
    end else if (policy_r == acmrr_pkg::POLICY_RANDOM) begin
      target = rnd_slot_r;
    end else begin
      target = recent_r;
    end
  end

  // ---------------------------------------------------------------------
  // Random victim: the next LFSR value modulo ENTRIES, prepared in two
  // stages while the generator holds still.
  assign rnd_next = acmrr_pkg::lfsr_step(lfsr_r);
  assign rnd_prod = {32'd0, rnd_next} * {16'd0, RECIP};
  assign rnd_qe   = {16'd0, rnd_q_r} * ENT32;
  assign rnd_rem  = rnd_val_r - rnd_qe[LFSR_W-1:0];

  always_ff @(posedge clk) begin
    rnd_val_r  <= rnd_next;
    rnd_q_r    <= rnd_prod[47:32];
    rnd_slot_r <= rnd_rem[IDX_W-1:0];
  end

  // ---------------------------------------------------------------------
  // Slot state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        valid_r[i] <= 1'b0;
      end
      recent_r  <= '0;
      lfsr_r    <= acmrr_pkg::LFSR_SEED;
      rnd_cnt_r <= 2'd2;
    end else begin
      if (do_match && is_insert && !free_any &&
          (policy_r == acmrr_pkg::POLICY_RANDOM)) begin
        lfsr_r    <= rnd_next;
        rnd_cnt_r <= 2'd2;
      end else if (rnd_cnt_r != 2'd0) begin
        rnd_cnt_r <= rnd_cnt_r - 2'd1;
      end
      if (do_match) begin
        if (is_insert) begin
          valid_r[target] <= 1'b1;
          recent_r        <= target;
        end else if (hit_any) begin
          recent_r <= hit_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_match && is_insert) begin
      key_r[target] <= req_key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (do_match) begin
      res_hit_r   <= !is_insert && hit_any;
      res_evict_r <= is_insert && !free_any;
      if (is_insert) begin
        res_slot_r <= target;
      end else begin
        res_slot_r <= hit_any ? hit_idx : '0;
      end
    end
  end

  acmrr_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (ENTRIES)
  ) u_payload_ram (
    .clk   (clk),
    .we    (do_match && is_insert),
    .waddr (target),
    .wdata (req_pay_r),
    .re    (do_match && !is_insert && hit_any),
    .raddr (hit_idx),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------
  // Output register.
  assign slot_wide = {{SLOT_W{1'b0}}, res_slot_r};
  assign pay_out   = res_hit_r ? PW'(ram_rdata) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_tdata_r <= {{(acmrr_pkg::OUT_TDATA_W-PW-SLOT_W){1'b0}},
                      slot_wide[SLOT_W-1:0], pay_out};
      out_tuser_r <= {res_evict_r, res_hit_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // ---------------------------------------------------------------------
  // Assertions.
  a_accept_to_match: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == acmrr_pkg::ST_MATCH))
    else $error("accepted item did not enter the compare cycle");

  a_insert_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (do_match && is_insert) |=> valid_r[$past(target)])
    else $error("inserted slot is not valid afterwards");

  a_hit_not_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> !out_tuser[1])
    else $error("result flags both hit and eviction");

  a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    lfsr_r != '0)
    else $error("random generator reached the all-zero lock-up state");

endmodule

// ===== verif/assoc_cache_mru_random_replace_tb.sv =====
// Self-checking testbench for the associative cache with MRU / random replacement.
// Predicts every result item from its own copy of the cache and compares it
// field by field. Depends on acmrr_pkg and the assoc_cache_mru_random_replace RTL.
`timescale 1ns / 100ps

module assoc_cache_mru_random_replace_tb;
  import acmrr_pkg::*;

  localparam int NUM_SLOTS       = ENTRIES_DEF;
  localparam int CLK_PERIOD      = 4;
  localparam int RESET_CYCLES    = 9;
  localparam int ITEMS_PER_PHASE = 470;
  localparam int KEY_POOL_SIZE   = 24;
  localparam int LONG_HOLD       = 400;
  localparam int DRAIN_CYCLES    = 8;
  localparam int IDLE_LIMIT      = 4000;

  typedef struct packed {
    logic                 hit;
    logic [PAYLOAD_W-1:0] payload;
    logic [SLOT_W-1:0]    slot;
    logic                 evicted;
  } cache_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr = '0;
  logic [CFG_DATA_W-1:0]  cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  // Predicted cache contents and replacement state.
  logic                 cache_valid [NUM_SLOTS];
  logic [KEY_W-1:0]     cache_key [NUM_SLOTS];
  logic [PAYLOAD_W-1:0] cache_payload [NUM_SLOTS];
  int                   recent_slot_idx;
  logic [LFSR_W-1:0]    victim_lfsr;
  policy_t              victim_policy;

  cache_result_t    expected_results[$];
  logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];

  int mismatch_count = 0;
  int results_checked = 0;
  int items_sent = 0;
  int lookup_hits = 0;
  int free_fills = 0;
  int mru_evictions = 0;
  int random_evictions = 0;
  int idle_cycles = 0;
  int hold_off_request = 0;

  assoc_cache_mru_random_replace #(
    .ENTRIES      (NUM_SLOTS),
    .PAYLOAD_BITS (PAYLOAD_BITS_DEF)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Applies one accepted item to the predicted cache and returns its result.
  function automatic cache_result_t predict_access(input op_t op, input logic [KEY_W-1:0] k,
                                                   input logic [PAYLOAD_W-1:0] p);
    cache_result_t r;
    int            target;
    logic          found;
    r = '0;
    target = 0;
    found = 1'b0;
    if (op == OP_LOOKUP) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!found && cache_valid[i] && cache_key[i] == k) begin
          found = 1'b1;
          target = i;
        end
      end
      if (found) begin
        r.hit = 1'b1;
        r.payload = cache_payload[target];
        r.slot = target[SLOT_W-1:0];
        recent_slot_idx = target;
        lookup_hits++;
      end
    end else begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!found && !cache_valid[i]) begin
          found = 1'b1;
          target = i;
        end
      end
      if (found) begin
        free_fills++;
      end else begin
        r.evicted = 1'b1;
        if (victim_policy == POLICY_RANDOM) begin
          // The generator only moves on when a random victim is actually chosen.
          victim_lfsr = victim_lfsr[0] ? ((victim_lfsr >> 1) ^ LFSR_TAPS) : (victim_lfsr >> 1);
          target = int'(victim_lfsr) % NUM_SLOTS;
          random_evictions++;
        end else begin
          target = recent_slot_idx % NUM_SLOTS;
          mru_evictions++;
        end
      end
      cache_valid[target] = 1'b1;
      cache_key[target] = k;
      cache_payload[target] = p;
      recent_slot_idx = target;
      r.slot = target[SLOT_W-1:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH at %0t: %s got %h expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Result checker: every accepted result item against the oldest prediction.
  always @(posedge clk) begin
    cache_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing outstanding", 64'(out_tdata), '0);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_tuser[0] !== want.hit)
          report_mismatch("hit", 64'(out_tuser[0]), 64'(want.hit));
        if (out_tdata[63:0] !== want.payload)
          report_mismatch("payload_out", out_tdata[63:0], want.payload);
        if (out_tdata[67:64] !== want.slot)
          report_mismatch("slot", 64'(out_tdata[67:64]), 64'(want.slot));
        if (out_tuser[1] !== want.evicted)
          report_mismatch("evicted", 64'(out_tuser[1]), 64'(want.evicted));
      end
    end
  end

  // Watchdog: ends the run when no handshake of any kind happens for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("assoc_cache_mru_random_replace_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: switches at random between stall patterns, and honours a
  // requested hold-off by counting the cycles itself.
  int rx_hold = 0;
  int rx_mode = 0;
  int rx_mode_left = 0;
  int rx_phase = 0;

  always @(negedge clk) begin
    if (hold_off_request > 0) begin
      rx_hold = hold_off_request;
      hold_off_request = 0;
    end
    if (rx_mode_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(20, 120);
    end
    rx_mode_left--;
    rx_phase++;
    if (rx_hold > 0) begin
      rx_hold--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 9) < 7);
        2: out_tready <= ((rx_phase % 5) < 3);
        default: out_tready <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  // Sends one item and leaves tvalid high, so that a burst runs without gaps.
  task automatic send_item(input op_t op, input logic [KEY_W-1:0] k,
                           input logic [PAYLOAD_W-1:0] p);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {p, k};
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(predict_access(op, k, p));
    items_sent++;
  endtask

  task automatic idle_input(input int cycles);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Writes the policy register once the block has drained, then reads it back.
  task automatic set_replace_policy(input policy_t policy);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_ADDR_W'({REG_REPLACE_POLICY, 2'b00});
    cfg_pwdata <= CFG_DATA_W'(policy);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    victim_policy = policy;
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== CFG_DATA_W'(policy))
      report_mismatch("replace_policy read-back", 64'(cfg_prdata), 64'(policy));
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Random traffic in bursts. Most keys come from a small pool so that
  // lookups hit often; the rest are fully random.
  task automatic run_random_traffic(input int n_items);
    int               burst_left;
    int               gap;
    op_t              op;
    logic [KEY_W-1:0] k;
    logic [PAYLOAD_W-1:0] p;
    burst_left = 0;
    for (int n = 0; n < n_items; n++) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        if (gap > 0) idle_input(gap);
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      op = ($urandom_range(0, 99) < 45) ? OP_INSERT : OP_LOOKUP;
      k = ($urandom_range(0, 3) == 0) ? KEY_W'($urandom)
                                       : key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
      case ($urandom_range(0, 9))
        0: p = '0;
        1: p = '1;
        default: p = {$urandom, $urandom};
      endcase
      send_item(op, k, p);
    end
    idle_input(1);
  endtask

  // Miss on an empty cache, fill every slot, the first ones with extreme keys
  // and payloads and a duplicate key, then evictions of the most recently used slot.
  task automatic test_directed_mru();
    logic [KEY_W-1:0]     k;
    logic [PAYLOAD_W-1:0] p;
    set_replace_policy(POLICY_MRU);
    send_item(OP_LOOKUP, 32'h0000_0000, '1);
    for (int i = 0; i < NUM_SLOTS; i++) begin
      case (i)
        0: k = 32'h8000_0000;
        1: k = 32'h7FFF_FFFF;
        2: k = 32'h0000_0000;
        3: k = 32'hFFFF_FFFF;
        4: k = 32'hA5A5_5A5A;
        5: k = 32'h5A5A_A5A5;
        6: k = 32'h7FFF_FFFF;  // same key again, so lookups must pick the lower slot
        default: k = $urandom;
      endcase
      case (i)
        0: p = '0;
        1: p = '1;
        2: p = 64'h5555_5555_5555_5555;
        3: p = 64'hAAAA_AAAA_AAAA_AAAA;
        default: p = {$urandom, $urandom};
      endcase
      key_pool[i] = k;
      send_item(OP_INSERT, k, p);
    end
    send_item(OP_LOOKUP, 32'h7FFF_FFFF, '0);
    send_item(OP_LOOKUP, 32'h8000_0000, '1);
    send_item(OP_INSERT, 32'h1234_5678, 64'hDEAD_BEEF_0123_4567);
    // A miss leaves the most recent slot where it was.
    send_item(OP_LOOKUP, 32'h0BAD_F00D, '0);
    send_item(OP_INSERT, 32'h8765_4321, 64'h0F0F_0F0F_F0F0_F0F0);
    send_item(OP_LOOKUP, 32'hFFFF_FFFF, '0);
    idle_input(1);
    for (int i = NUM_SLOTS; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom;
  endtask

  task automatic test_mru_traffic();
    run_random_traffic(ITEMS_PER_PHASE);
  endtask

  task automatic test_random_replacement();
    set_replace_policy(POLICY_RANDOM);
    run_random_traffic(ITEMS_PER_PHASE);
  endtask

  // The receiver holds off for a long stretch while items keep coming, so the
  // block fills up and stalls its input.
  task automatic test_backpressure();
    set_replace_policy(POLICY_MRU);
    hold_off_request = LONG_HOLD;
    run_random_traffic(ITEMS_PER_PHASE);
  endtask

  task automatic test_policy_switch();
    set_replace_policy(POLICY_RANDOM);
    run_random_traffic(ITEMS_PER_PHASE / 2);
    set_replace_policy(POLICY_MRU);
    run_random_traffic(ITEMS_PER_PHASE / 2);
  endtask

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      cache_valid[i] = 1'b0;
      cache_key[i] = '0;
      cache_payload[i] = '0;
    end
    recent_slot_idx = 0;
    victim_lfsr = LFSR_SEED;
    victim_policy = POLICY_MRU;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_mru();
    test_mru_traffic();
    test_random_replacement();
    test_backpressure();
    test_policy_switch();

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d items and %0d checked results: %0d lookup hits, %0d free-slot fills,",
             items_sent, results_checked, lookup_hits, free_fills);
    $display("  %0d MRU evictions and %0d random evictions; %0d mismatches.",
             mru_evictions, random_evictions, mismatch_count);
    if (mismatch_count == 0) begin
      $display("assoc_cache_mru_random_replace_tb passed");
    end else begin
      $display("assoc_cache_mru_random_replace_tb failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/acmrr_pkg.sv
hw/rtl/acmrr_ram.sv
hw/rtl/assoc_cache_mru_random_replace.sv
verif/assoc_cache_mru_random_replace_tb.sv
